[hw/rtl/color_sensor_frequency_classifier_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker of the classifier core.
// ----------------------------------------------------------------------------
`ifndef COLOR_SENSOR_FREQUENCY_CLASSIFIER_CORE_MACROS_SVH
`define COLOR_SENSOR_FREQUENCY_CLASSIFIER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSFC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/csfc_pkg.sv]
// ----------------------------------------------------------------------------
// csfc_pkg
// Types and constants shared by the color sensor frequency classifier.
// ----------------------------------------------------------------------------
package csfc_pkg;

    localparam int FREQ_W = 32;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_WHITE_LEVEL = 3'd0;
    localparam logic [IDX_W-1:0] REG_DARK_CLEAR  = 3'd1;
    localparam logic [IDX_W-1:0] REG_DARK_RED    = 3'd2;
    localparam logic [IDX_W-1:0] REG_DARK_BLUE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DARK_GREEN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_MID_LEVEL   = 3'd5;
    localparam logic [IDX_W-1:0] REG_BLUE_FLOOR  = 3'd6;

    // Filter channel codes.
    localparam logic [1:0] CH_CLEAR = 2'd0;
    localparam logic [1:0] CH_RED   = 2'd1;
    localparam logic [1:0] CH_GREEN = 2'd2;
    localparam logic [1:0] CH_BLUE  = 2'd3;

    typedef enum logic [2:0] {
        CLS_BIG_GREEN = 3'd0,
        CLS_WHITE     = 3'd1,
        CLS_BLACK     = 3'd2,
        CLS_GREEN     = 3'd3,
        CLS_BLUE      = 3'd4,
        CLS_RED       = 3'd5,
        CLS_UNKNOWN   = 3'd6
    } color_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_START = 2'd1,
        ST_DIV   = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

    // Status reported by the divider.
    typedef struct packed {
        logic done;
        logic saturated;
    } div_stat_t;

endpackage

[hw/rtl/color_sensor_frequency_classifier_core.sv]
// ----------------------------------------------------------------------------
// color_sensor_frequency_classifier_core
// An accepted request goes through ST_START and ST_DIV to ST_DONE, or straight
// to ST_DONE when the block is not yet primed or the time difference is zero.
// No new request is taken until the result enters the output register. The
// bit-serial divider produces one quotient bit per cycle while it runs.
// Reset (rst_n, asynchronous, active low) restores the register defaults,
// clears the stored snapshot and frequencies and sets the color to unknown.
// ----------------------------------------------------------------------------
module color_sensor_frequency_classifier_core #(
    parameter int TIMER_HZ = 100000000
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [csfc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [csfc_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [31:0]                 pulse_count,
    input  logic [31:0]                 timestamp,
    input  logic [1:0]                  channel,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 frequency_hz,
    output logic                        color_valid,
    output logic [2:0]                  color_class
);
    import csfc_pkg::*;

    // Threshold registers.
    logic [CFG_W-1:0] white_level_reg;
    logic [CFG_W-1:0] dark_clear_reg;
    logic [CFG_W-1:0] dark_red_reg;
    logic [CFG_W-1:0] dark_blue_reg;
    logic [CFG_W-1:0] dark_green_reg;
    logic [CFG_W-1:0] mid_level_reg;
    logic [CFG_W-1:0] blue_floor_reg;

    // Stored snapshot, stored channel frequencies and the last color.
    logic [31:0] prev_count_reg;
    logic [31:0] prev_time_reg;
    logic [31:0] clear_freq_reg;
    logic [31:0] red_freq_reg;
    logic [31:0] green_freq_reg;
    color_t      last_color_reg;

    // Request being worked on.
    state_t      state_reg;
    state_t      state_next;
    logic [31:0] dc_reg;
    logic [31:0] dt_reg;
    logic [1:0]  ch_reg;
    logic [31:0] freq_reg;

    // Output register.
    logic        out_valid_reg;
    logic [31:0] out_freq_reg;
    logic        out_cv_reg;
    logic [2:0]  out_class_reg;

    logic        accept;
    logic        div_start;
    logic        load_out;
    logic [31:0] dc_next;
    logic [31:0] dt_next;
    logic        zero_freq;
    logic [31:0] quotient;
    div_stat_t   div_stat;
    color_t      color_next;

    // Differences wrap modulo 2^32 just like the free-running counters. A
    // stored timestamp of zero means no earlier snapshot exists yet, and a
    // zero time difference gives no meaningful rate; both report zero and
    // skip the divider entirely.
    assign accept    = in_valid & in_ready;
    assign dc_next   = pulse_count - prev_count_reg;
    assign dt_next   = timestamp - prev_time_reg;
    assign zero_freq = (prev_time_reg == '0) || (dt_next == '0);

    csfc_divider #(
        .TIMER_HZ (TIMER_HZ)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dc       (dc_reg),
        .dt       (dt_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Sequencer: take a request, run the divider when a rate is needed, then
    // hand the result to the output register as soon as it is free.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = zero_freq ? ST_DONE : ST_START;
                end
            end
            ST_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_START);
        load_out  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    // Threshold decision tree. The clear, red and green values come from the
    // stored set and the blue value is the frequency just measured. When no
    // branch matches, the previous color stands.
    always_comb
    begin
        logic [31:0] c;
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        c = clear_freq_reg;
        r = red_freq_reg;
        g = green_freq_reg;
        b = freq_reg;
        color_next = last_color_reg;
        if (c > {8'd0, white_level_reg})
        begin
            color_next = ((g > r) && (g > b)) ? CLS_BIG_GREEN : CLS_WHITE;
        end
        else if ((c < {8'd0, dark_clear_reg}) && (r < {8'd0, dark_red_reg}) &&
                 (b < {8'd0, dark_blue_reg}) && (g < {8'd0, dark_green_reg}))
        begin
            color_next = CLS_BLACK;
        end
        else if ((c > {8'd0, mid_level_reg}) && (g > b))
        begin
            color_next = CLS_GREEN;
        end
        else if ((c > {8'd0, mid_level_reg}) && (b > g) &&
                 (b > {8'd0, blue_floor_reg}))
        begin
            color_next = CLS_BLUE;
        end
        else if ((r > b) && (r > g))
        begin
            color_next = CLS_RED;
        end
    end

    // Control state, thresholds and the stored measurement set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            white_level_reg <= CFG_W'(17000);
            dark_clear_reg  <= CFG_W'(8300);
            dark_red_reg    <= CFG_W'(6000);
            dark_blue_reg   <= CFG_W'(6000);
            dark_green_reg  <= CFG_W'(5000);
            mid_level_reg   <= CFG_W'(9000);
            blue_floor_reg  <= CFG_W'(6000);
            prev_count_reg  <= '0;
            prev_time_reg   <= '0;
            clear_freq_reg  <= '0;
            red_freq_reg    <= '0;
            green_freq_reg  <= '0;
            last_color_reg  <= CLS_UNKNOWN;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WHITE_LEVEL: white_level_reg <= cfg_data;
                    REG_DARK_CLEAR:  dark_clear_reg  <= cfg_data;
                    REG_DARK_RED:    dark_red_reg    <= cfg_data;
                    REG_DARK_BLUE:   dark_blue_reg   <= cfg_data;
                    REG_DARK_GREEN:  dark_green_reg  <= cfg_data;
                    REG_MID_LEVEL:   mid_level_reg   <= cfg_data;
                    REG_BLUE_FLOOR:  blue_floor_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // Every snapshot replaces the stored one, including the priming
            // snapshot and one with a repeated timestamp.
            if (accept)
            begin
                prev_count_reg <= pulse_count;
                prev_time_reg  <= timestamp;
            end

            if (load_out)
            begin
                case (ch_reg)
                    CH_CLEAR: clear_freq_reg <= freq_reg;
                    CH_RED:   red_freq_reg   <= freq_reg;
                    CH_GREEN: green_freq_reg <= freq_reg;
                    default:  last_color_reg <= color_next;
                endcase
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dc_reg <= dc_next;
            dt_reg <= dt_next;
            ch_reg <= channel;
            if (zero_freq)
            begin
                freq_reg <= '0;
            end
        end
        else if ((state_reg == ST_DIV) && div_stat.done)
        begin
            freq_reg <= div_stat.saturated ? '1 : quotient;
        end

        if (load_out)
        begin
            out_freq_reg  <= freq_reg;
            out_cv_reg    <= (ch_reg == CH_BLUE);
            out_class_reg <= (ch_reg == CH_BLUE) ? color_next : CLS_BIG_GREEN;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frequency_hz = out_freq_reg;
    assign color_valid  = out_cv_reg;
    assign color_class  = out_class_reg;

endmodule

[hw/rtl/csfc_divider.sv]
// ----------------------------------------------------------------------------
// csfc_divider
// Scales a count difference by the timer rate and divides it by the time
// difference, one quotient bit per cycle, flagging a quotient above 32 bits.
// ----------------------------------------------------------------------------
module csfc_divider #(
    parameter int TIMER_HZ = 100000000
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          dc,
    input  logic [31:0]          dt,
    output logic [31:0]          quotient,
    output csfc_pkg::div_stat_t  stat
);
    import csfc_pkg::*;

    localparam int TW    = $clog2(TIMER_HZ + 1);
    localparam int NW    = FREQ_W + TW;
    localparam int STEPS = FREQ_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [NW-1:0]     prod_reg;
    logic [NW-1:0]     prod_next;
    logic [31:0]       dt_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       quo_reg;
    logic              sat_reg;
    logic              run_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [32:0]       trial;
    logic [32:0]       diff;
    logic              take;
    logic [TW-1:0]     rate;

    assign rate      = TW'(TIMER_HZ);
    assign prod_next = {{TW{1'b0}}, dc} * {{FREQ_W{1'b0}}, rate};

    // One restoring step: the next dividend bit shifts out of the top of the
    // quotient register while the quotient bit shifts in at the bottom.
    assign trial = {rem_reg, quo_reg[31]};
    assign diff  = trial - {1'b0, dt_reg};
    assign take  = ~diff[32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod_next;
            dt_reg   <= dt;
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                // The quotient fits in 32 bits only when the upper part of
                // the product is below the divisor.
                sat_reg <= ({{(32-TW){1'b0}}, prod_reg[NW-1:FREQ_W]} >= dt_reg);
                rem_reg <= {{(32-TW){1'b0}}, prod_reg[NW-1:FREQ_W]};
                quo_reg <= prod_reg[FREQ_W-1:0];
            end
            else
            begin
                rem_reg <= take ? diff[31:0] : trial[31:0];
                quo_reg <= {quo_reg[30:0], take};
            end
        end
    end

    assign quotient       = quo_reg;
    assign stat.done      = done_reg;
    assign stat.saturated = sat_reg;

endmodule

[hw/rtl/csfc_checker.sv]
// ----------------------------------------------------------------------------
// csfc_checker
// Port-level checks on the classifier core, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "color_sensor_frequency_classifier_core_macros.svh"

module csfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] frequency_hz,
    input logic        color_valid,
    input logic [2:0]  color_class
);
    import csfc_pkg::*;

    // A stalled result keeps its value.
    `CSFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frequency_hz) && $stable(color_valid) && $stable(color_class), "result changed while stalled")

    // The block works on one request at a time.
    `CSFC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while busy")

    // Results without a color decision carry a class code of zero.
    `CSFC_ASSERT_SAME(a_class_zero, out_valid && !color_valid, color_class == CLS_BIG_GREEN, "class set without color decision")

endmodule

bind color_sensor_frequency_classifier_core csfc_checker u_csfc_checker (.*);
